// ===== design/assert_macros.svh =====
// Assertion macros used by the matrix chain cost core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MCMC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MCMC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MCMC_ASSERT(lbl, clk, rst_n, prop)
`define MCMC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== design/mcmc_pkg.sv =====
// Package: types, constants and state codes of the matrix chain cost block.
`timescale 1ns / 1ps
package mcmc_pkg;

    localparam int MAX_MATRICES_DEF = 32;
    localparam int DIM_BITS_DEF     = 16;
    localparam int IN_DIM_W         = 16;
    localparam int COST_W           = 63;
    localparam int STATUS_W         = 2;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_MISMATCH = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [IN_DIM_W-1:0] rows;
        logic [IN_DIM_W-1:0] cols;
        logic                last;
    } t_in;

    typedef struct packed {
        logic [COST_W-1:0] min_cost;
        t_status           status;
    } t_out;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_SPAN,
        S_SPAN_HI,
        S_SPAN_LO,
        S_K_A,
        S_K_B,
        S_K_C,
        S_K_D,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

// ===== design/matrix_chain_min_cost_core.sv =====
// Top level: matrix chain minimum cost, dimension and span cost tables in RAM.
// Load: one shape per cycle, except while a chain is being solved or a held result blocks a
// last shape; a chain with an error or a single matrix gives its result in the cycle after the
// last transfer. Otherwise the span cost table is filled one span at a time by the serial
// split step: two cost reads on one port, two multiplies, one compare. One chain at a time.
// Reset clears the state machine, counter, flags and output valid; RAM is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module matrix_chain_min_cost_core
    import mcmc_pkg::*;
#(
    parameter int MAX_MATRICES = MAX_MATRICES_DEF,
    parameter int DIM_BITS     = DIM_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int IW    = $clog2(MAX_MATRICES);
    localparam int CW    = $clog2(MAX_MATRICES + 1);
    localparam int AW    = 2 * IW;
    localparam int CDEP  = 1 << AW;
    localparam int P1W   = 2 * DIM_BITS;
    localparam int P2W   = 3 * DIM_BITS;
    localparam int SUM_W = COST_W + 1;

    t_state r_state, n_state;

    logic [CW-1:0]       r_count, n_count;
    logic                r_mismatch, n_mismatch;
    logic                r_overflow, n_overflow;
    logic [DIM_BITS-1:0] r_dim0, n_dim0;
    logic [DIM_BITS-1:0] r_prev_cols, n_prev_cols;
    logic [CW-1:0]       r_n, n_n;
    logic [CW-1:0]       r_len, n_len;
    logic [IW-1:0]       r_lo, n_lo;
    logic [IW-1:0]       r_hi, n_hi;
    logic [IW-1:0]       r_k, n_k;
    logic [DIM_BITS-1:0] r_p_lo, n_p_lo;
    logic [DIM_BITS-1:0] r_p_hi, n_p_hi;
    logic [P1W-1:0]      r_prod1, n_prod1;
    logic [P2W-1:0]      r_prod2, n_prod2;
    logic [COST_W-1:0]   r_cost_a, n_cost_a;
    logic [COST_W-1:0]   r_sum, n_sum;
    logic [COST_W-1:0]   r_best, n_best;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    logic                in_xfer;
    logic [DIM_BITS-1:0] in_rows;
    logic [DIM_BITS-1:0] in_cols;
    logic [SUM_W-1:0]    ab_sum;
    logic [SUM_W-1:0]    c_sum;
    logic [COST_W-1:0]   c_sat;
    t_status             fin_status;

    logic                dim_we;
    logic [IW-1:0]       dim_waddr;
    logic                dim_re;
    logic [IW-1:0]       dim_raddr;
    logic [DIM_BITS-1:0] dim_rdata;
    logic                cost_we;
    logic [AW-1:0]       cost_waddr;
    logic [COST_W-1:0]   cost_wdata;
    logic                cost_re;
    logic [AW-1:0]       cost_raddr;
    logic [COST_W-1:0]   cost_rdata;

    mcmc_ram #(
        .WIDTH (DIM_BITS),
        .DEPTH (MAX_MATRICES)
    ) u_dim_ram (
        .i_clk   (i_clk),
        .i_we    (dim_we),
        .i_waddr (dim_waddr),
        .i_wdata (in_cols),
        .i_re    (dim_re),
        .i_raddr (dim_raddr),
        .o_rdata (dim_rdata)
    );

    mcmc_ram #(
        .WIDTH (COST_W),
        .DEPTH (CDEP)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (cost_we),
        .i_waddr (cost_waddr),
        .i_wdata (cost_wdata),
        .i_re    (cost_re),
        .i_raddr (cost_raddr),
        .o_rdata (cost_rdata)
    );

    assign o_in_stall  = (r_state != S_LOAD) || (r_out_valid && i_in.last);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign in_rows     = i_in.rows[DIM_BITS-1:0];
    assign in_cols     = i_in.cols[DIM_BITS-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign ab_sum = {1'b0, r_cost_a} + {1'b0, cost_rdata};
    assign c_sum  = {1'b0, r_sum} + {{(SUM_W - P2W){1'b0}}, r_prod2};
    assign c_sat  = c_sum[SUM_W-1] ? COST_MAX : c_sum[COST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_mismatch  <= 1'b0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mismatch  <= n_mismatch;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dim0      <= n_dim0;
        r_prev_cols <= n_prev_cols;
        r_n         <= n_n;
        r_len       <= n_len;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_k         <= n_k;
        r_p_lo      <= n_p_lo;
        r_p_hi      <= n_p_hi;
        r_prod1     <= n_prod1;
        r_prod2     <= n_prod2;
        r_cost_a    <= n_cost_a;
        r_sum       <= n_sum;
        r_best      <= n_best;
        r_out       <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_mismatch  = r_mismatch;
        n_overflow  = r_overflow;
        n_dim0      = r_dim0;
        n_prev_cols = r_prev_cols;
        n_n         = r_n;
        n_len       = r_len;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_k         = r_k;
        n_p_lo      = r_p_lo;
        n_p_hi      = r_p_hi;
        n_prod1     = r_prod1;
        n_prod2     = r_prod2;
        n_cost_a    = r_cost_a;
        n_sum       = r_sum;
        n_best      = r_best;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        fin_status  = ST_OK;
        dim_we      = 1'b0;
        dim_waddr   = r_count[IW-1:0];
        dim_re      = 1'b0;
        dim_raddr   = r_hi;
        cost_we     = 1'b0;
        cost_waddr  = {r_lo, r_hi};
        cost_wdata  = r_best;
        cost_re     = 1'b0;
        cost_raddr  = {r_lo, r_k};

        unique case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    if (r_count < CW'(MAX_MATRICES)) begin
                        if (r_count == '0) begin
                            n_dim0 = in_rows;
                        end else if (r_prev_cols != in_rows) begin
                            n_mismatch = 1'b1;
                        end
                        dim_we      = 1'b1;
                        n_prev_cols = in_cols;
                        n_count     = r_count + 1'b1;
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_in.last) begin
                        if (n_overflow) begin
                            fin_status = ST_OVERFLOW;
                        end else if (n_mismatch) begin
                            fin_status = ST_MISMATCH;
                        end
                        if (fin_status != ST_OK || n_count < CW'(2)) begin
                            n_out_valid = 1'b1;
                            n_out       = '{min_cost: '0, status: fin_status};
                        end else begin
                            n_n     = n_count;
                            n_lo    = '0;
                            n_state = S_INIT;
                        end
                        n_count    = '0;
                        n_mismatch = 1'b0;
                        n_overflow = 1'b0;
                    end
                end
            end
            S_INIT: begin
                cost_we    = 1'b1;
                cost_waddr = {r_lo, r_lo};
                cost_wdata = '0;
                if (CW'(r_lo) == r_n - 1'b1) begin
                    n_len   = CW'(2);
                    n_lo    = '0;
                    n_hi    = IW'(1);
                    n_state = S_SPAN;
                end else begin
                    n_lo = r_lo + 1'b1;
                end
            end
            S_SPAN: begin
                dim_re    = 1'b1;
                dim_raddr = r_hi;
                n_state   = S_SPAN_HI;
            end
            S_SPAN_HI: begin
                n_p_hi    = dim_rdata;
                dim_re    = (r_lo != '0);
                dim_raddr = r_lo - 1'b1;
                n_state   = S_SPAN_LO;
            end
            S_SPAN_LO: begin
                n_p_lo  = (r_lo == '0) ? r_dim0 : dim_rdata;
                n_k     = r_lo;
                n_best  = COST_MAX;
                n_state = S_K_A;
            end
            S_K_A: begin
                dim_re     = 1'b1;
                dim_raddr  = r_k;
                cost_re    = 1'b1;
                cost_raddr = {r_lo, r_k};
                n_state    = S_K_B;
            end
            S_K_B: begin
                n_prod1    = P1W'(r_p_lo) * P1W'(dim_rdata);
                n_cost_a   = cost_rdata;
                cost_re    = 1'b1;
                cost_raddr = {r_k + 1'b1, r_hi};
                n_state    = S_K_C;
            end
            S_K_C: begin
                n_prod2 = P2W'(r_prod1) * P2W'(r_p_hi);
                n_sum   = ab_sum[SUM_W-1] ? COST_MAX : ab_sum[COST_W-1:0];
                n_state = S_K_D;
            end
            S_K_D: begin
                if (c_sat < r_best) begin
                    n_best = c_sat;
                end
                if (r_k == r_hi - 1'b1) begin
                    n_state = S_WRITE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_K_A;
                end
            end
            S_WRITE: begin
                cost_we = 1'b1;
                if (CW'(r_hi) == r_n - 1'b1) begin
                    if (r_len == r_n) begin
                        n_state = S_DONE;
                    end else begin
                        n_len   = r_len + 1'b1;
                        n_lo    = '0;
                        n_hi    = IW'(r_len);
                        n_state = S_SPAN;
                    end
                end else begin
                    n_lo    = r_lo + 1'b1;
                    n_hi    = r_hi + 1'b1;
                    n_state = S_SPAN;
                end
            end
            S_DONE: begin
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out       = '{min_cost: r_best, status: ST_OK};
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    `MCMC_ASSERT(a_err_zero_cost, i_clk, i_rst_n, o_out_valid && o_out.status != ST_OK |-> o_out.min_cost == '0)
    `MCMC_ASSERT(a_xfer_in_load, i_clk, i_rst_n, in_xfer |-> r_state == S_LOAD)
    `MCMC_ASSERT(a_cost_port_excl, i_clk, i_rst_n, cost_we |-> !cost_re)
    `MCMC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_MATRICES))
    `MCMC_ASSERT(a_split_in_span, i_clk, i_rst_n, r_state == S_K_D |-> r_k < r_hi && r_lo <= r_k)

endmodule

// ===== design/mcmc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module mcmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/sv/matrix_chain_cost_checker.sv =====
// Checker: predicts the minimum chain cost and status, compares each result transfer.
`timescale 1ns / 1ps
module matrix_chain_cost_checker
    import mcmc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out,
    output int   o_fail_count,
    output int   o_waiting
);

    localparam int          NMAX = MAX_MATRICES_DEF;
    localparam logic [63:0] SAT  = {1'b0, COST_MAX};

    logic [DIM_BITS_DEF-1:0] chain_dims [0:NMAX];
    logic [63:0]             span_cost [0:NMAX-1][0:NMAX-1];
    int unsigned             shapes_held = 0;
    bit                      dims_mismatched = 1'b0;
    bit                      chain_overrun = 1'b0;
    t_out                    expected_costs [$];
    int                      fail_total = 0;

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, SAT}) ? SAT : s[63:0];
    endfunction

    function automatic logic [63:0] chain_min_cost(input int unsigned n);
        logic [63:0] best;
        logic [63:0] prod;
        logic [63:0] c;
        for (int lo = 0; lo < n; lo++) span_cost[lo][lo] = '0;
        for (int len = 2; len <= n; len++) begin
            for (int lo = 0; lo + len <= n; lo++) begin
                best = SAT;
                for (int k = lo; k < lo + len - 1; k++) begin
                    prod = 64'(chain_dims[lo]) * 64'(chain_dims[k+1])
                         * 64'(chain_dims[lo+len]);
                    c = sat_sum(sat_sum(span_cost[lo][k], span_cost[k+1][lo+len-1]), prod);
                    if (c < best) best = c;
                end
                span_cost[lo][lo+len-1] = best;
            end
        end
        return span_cost[0][n-1];
    endfunction

    task automatic take_shape(input t_in item);
        logic [DIM_BITS_DEF-1:0] r;
        logic [DIM_BITS_DEF-1:0] c;
        logic [63:0]             total;
        t_out                    res;
        r = item.rows[DIM_BITS_DEF-1:0];
        c = item.cols[DIM_BITS_DEF-1:0];
        if (shapes_held < NMAX) begin
            if (shapes_held == 0) chain_dims[0] = r;
            else if (chain_dims[shapes_held] != r) dims_mismatched = 1'b1;
            chain_dims[shapes_held+1] = c;
            shapes_held++;
        end else begin
            chain_overrun = 1'b1;
        end
        if (item.last) begin
            res.min_cost = '0;
            res.status   = ST_OK;
            if (chain_overrun) begin
                res.status = ST_OVERFLOW;
            end else if (dims_mismatched) begin
                res.status = ST_MISMATCH;
            end else if (shapes_held >= 2) begin
                total        = chain_min_cost(shapes_held);
                res.min_cost = total[COST_W-1:0];
            end
            expected_costs.push_back(res);
            shapes_held     = 0;
            dims_mismatched = 1'b0;
            chain_overrun   = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            shapes_held     = 0;
            dims_mismatched = 1'b0;
            chain_overrun   = 1'b0;
            expected_costs.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_costs.size() == 0) begin
                    $error("unexpected result: min_cost %0d status %0d",
                           i_out.min_cost, i_out.status);
                    fail_total++;
                end else begin
                    want = expected_costs.pop_front();
                    if (i_out.min_cost !== want.min_cost) begin
                        $error("min_cost: expected %0d, actual %0d",
                               want.min_cost, i_out.min_cost);
                        fail_total++;
                    end
                    if (i_out.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_out.status);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) take_shape(i_in);
        end
        o_fail_count <= fail_total;
        o_waiting    <= expected_costs.size();
    end

endmodule

// ===== tb/sv/tb_matrix_chain_min_cost_core.sv =====
// Testbench top: drives matrix chains into the core, stalls the result side, gives the verdict.
`timescale 1ns / 1ps
module tb_matrix_chain_min_cost_core
    import mcmc_pkg::*;
();

    localparam int RANDOM_ITEMS = 2000;
    localparam int IDLE_LIMIT   = 200000;
    localparam int TAIL_CYCLES  = 100;

    typedef enum {CHAIN_GOOD, CHAIN_BROKEN, CHAIN_NOISE} t_chain_kind;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_shape  = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_result;

    int fail_count;
    int waiting;
    int burst_left  = 0;
    int items_sent  = 0;
    int idle_cycles = 0;
    int stall_mode  = 0;
    int stall_hold  = 0;

    always #5 clk = ~clk;

    matrix_chain_min_cost_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_shape),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_result)
    );

    matrix_chain_cost_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_shape),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_result),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    always @(posedge clk) begin
        if (stall_hold == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_hold <= $urandom_range(20, 200);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return 16'($urandom);
            4, 5: return 16'($urandom_range(1, 1000));
            default: return 16'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) return MAX_MATRICES_DEF;
        if (roll < 6) return $urandom_range(MAX_MATRICES_DEF + 1, MAX_MATRICES_DEF + 8);
        if (roll < 12) return $urandom_range(9, MAX_MATRICES_DEF - 1);
        return $urandom_range(1, 8);
    endfunction

    task automatic send_shape(input logic [15:0] r, input logic [15:0] c, input logic l);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid      <= 1'b1;
        in_shape.rows <= r;
        in_shape.cols <= c;
        in_shape.last <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_chain(input int n, input t_chain_kind kind);
        logic [15:0] p [0:MAX_MATRICES_DEF+8];
        logic [15:0] r;
        int          bad;
        for (int i = 0; i <= n; i++) p[i] = pick_dim();
        bad = (n > 1) ? $urandom_range(1, n - 1) : 0;
        for (int i = 0; i < n; i++) begin
            r = p[i];
            if (kind == CHAIN_NOISE) r = pick_dim();
            else if (kind == CHAIN_BROKEN && n > 1 && i == bad)
                r = p[i] ^ 16'($urandom_range(1, 65535));
            send_shape(r, p[i+1], i == n - 1);
        end
    endtask

    initial begin : stimulus
        int          random_start;
        int          roll;
        t_chain_kind kind;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_shape(16'd0, 16'hFFFF, 1'b1);
        send_shape(16'hFFFF, 16'd0, 1'b1);
        send_shape(16'd10, 16'd30, 1'b0);
        send_shape(16'd30, 16'd5, 1'b0);
        send_shape(16'd5, 16'd60, 1'b1);
        send_shape(16'hFFFF, 16'hFFFF, 1'b0);
        send_shape(16'hFFFF, 16'hFFFF, 1'b1);
        send_shape(16'hFFFF, 16'hFFFF, 1'b0);
        send_shape(16'hFFFF, 16'hFFFF, 1'b0);
        send_shape(16'hFFFF, 16'hFFFF, 1'b1);
        send_shape(16'd2, 16'd3, 1'b0);
        send_shape(16'd4, 16'd5, 1'b1);
        send_shape(16'd0, 16'd0, 1'b0);
        send_shape(16'd0, 16'd0, 1'b0);
        send_shape(16'd0, 16'd7, 1'b1);
        send_shape(16'd1, 16'd2, 1'b0);
        send_shape(16'd2, 16'd3, 1'b0);
        send_shape(16'd9, 16'd4, 1'b1);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) kind = CHAIN_GOOD;
            else if (roll < 90) kind = CHAIN_BROKEN;
            else kind = CHAIN_NOISE;
            send_chain(pick_length(), kind);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && waiting == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
